// File: rtl/core/rate_monotonic_tick_scheduler_assert.svh
// assertion macros for the rate-monotonic tick scheduler
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
// clocked assertion with explicit clock and reset
`define RMTS_ASSERT_CLK(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("rmts assertion failed");
// clocked assertion on the block clock and reset
`define RMTS_ASSERT(label, prop) `RMTS_ASSERT_CLK(label, clk, rst, prop)
`else
`define RMTS_ASSERT_CLK(label, clk_sig, rst_sig, prop)
`define RMTS_ASSERT(label, prop)
`endif

`endif

// File: rtl/core/rmts_pkg.sv
// shared types, constants and helpers of the rate-monotonic tick scheduler
package rmts_pkg;

  localparam int NUM_TASKS   = 8;
  localparam int TASK_SLOTS  = 8;
  localparam int TASK_IDX_W  = 3;
  localparam int TIME_W      = 32;
  localparam int WORK_W      = 16;
  localparam int CFG_W       = 32;

  // one task register: burst in the upper half, period in the lower half
  typedef struct packed {
    logic [WORK_W-1:0] burst;
    logic [WORK_W-1:0] period;
  } task_cfg_t;

  // clamp a 32-bit difference to 16 bits
  function automatic logic [WORK_W-1:0] sat16(input logic [TIME_W-1:0] v);
    logic [WORK_W-1:0] r;
    r = (v > TIME_W'({WORK_W{1'b1}})) ? {WORK_W{1'b1}} : v[WORK_W-1:0];
    return r;
  endfunction

endpackage

// File: rtl/core/rate_monotonic_tick_scheduler.sv
// rate-monotonic tick scheduler: one time tick per input word, one result word per tick
//
// Usage: each input word (restart) advances time by one tick. Every enabled
// task releases a job at tick 0 and once per period; the ready task with the
// shortest period (lowest index on ties) runs one unit. Each tick yields one
// result word: which task ran, job completion with finish time, turnaround
// and waiting, and a mask of releases that found the previous job unfinished.
// Task registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle; the block itself does not enforce this. A word
// passes the input register, then the result register; one per cycle unless the
// receiver stalls. Release compare, priority pick and completion math form one stage.
// Reset (rst, synchronous) clears the task registers, time and task state.
// When the receiver stalls, the result register holds; the input register
// still takes one word, after which in_stall rises until the result moves.
`include "rate_monotonic_tick_scheduler_assert.svh"

module rate_monotonic_tick_scheduler (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [rmts_pkg::TASK_IDX_W-1:0]    cfg_index,
  input  logic [rmts_pkg::CFG_W-1:0]         cfg_data,
  // tick input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               restart,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               scheduled,
  output logic [rmts_pkg::TASK_IDX_W-1:0]    task_res,
  output logic                               job_done,
  output logic [rmts_pkg::TIME_W-1:0]        finish_time,
  output logic [rmts_pkg::WORK_W-1:0]        turnaround,
  output logic [rmts_pkg::WORK_W-1:0]        waiting,
  output logic [rmts_pkg::NUM_TASKS-1:0]     overrun_mask
);

  localparam int N  = rmts_pkg::NUM_TASKS;
  localparam int TW = rmts_pkg::TIME_W;
  localparam int WW = rmts_pkg::WORK_W;
  localparam int IW = rmts_pkg::TASK_IDX_W;

  // configuration and scheduler state
  rmts_pkg::task_cfg_t     task_cfg [rmts_pkg::TASK_SLOTS];
  logic [TW-1:0]           now;
  logic [WW-1:0]           remaining [N];
  logic [TW-1:0]           next_release [N];
  logic [TW-1:0]           release_time [N];

  // input register
  logic                    in_vld_r;
  logic                    in_restart_r;

  // handshake control
  logic                    advance;
  logic                    proc;

  // tick computation
  logic [TW-1:0]           now_e;
  logic [TW-1:0]           fin;
  logic [N-1:0]            due;
  logic [N-1:0]            ovr;
  logic [WW-1:0]           rem_rel [N];
  logic [TW-1:0]           rt_rel [N];
  logic [TW-1:0]           full [N];
  logic [WW-1:0]           remaining_next [N];
  logic [TW-1:0]           next_release_next [N];
  logic                    found;
  logic [IW-1:0]           pick;
  logic [WW-1:0]           best;
  logic                    done;
  logic [TW-1:0]           full_k;
  logic [WW-1:0]           burst_k;
  logic [WW-1:0]           tat;
  logic [WW-1:0]           wt;

  assign advance  = !out_valid || !out_stall;
  assign proc     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  // release, pick and completion for the tick in the input register
  always_comb begin
    logic [WW-1:0] rem_e;
    logic [TW-1:0] nr_e;
    logic [TW-1:0] rt_e;
    logic [WW-1:0] per;
    now_e = in_restart_r ? '0 : now;
    fin   = now_e + TW'(1);
    found = 1'b0;
    pick  = '0;
    best  = '0;
    for (int i = 0; i < N; i++) begin
      rem_e = in_restart_r ? '0 : remaining[i];
      nr_e  = in_restart_r ? '0 : next_release[i];
      rt_e  = in_restart_r ? '0 : release_time[i];
      per   = task_cfg[i].period;
      due[i] = (per != '0) && (now_e == nr_e);
      ovr[i] = due[i] && (rem_e != '0);
      rem_rel[i] = due[i] ? task_cfg[i].burst : rem_e;
      rt_rel[i]  = due[i] ? now_e : rt_e;
      next_release_next[i] = due[i] ? (now_e + {{(TW-WW){1'b0}}, per}) : nr_e;
      full[i] = fin - rt_rel[i];
      // shortest period wins, strict compare keeps the lowest index on ties
      if ((per != '0) && (rem_rel[i] != '0) && (!found || per < best)) begin
        found = 1'b1;
        pick  = IW'(i);
        best  = per;
      end
    end
    for (int i = 0; i < N; i++) begin
      remaining_next[i] = (found && pick == IW'(i)) ? (rem_rel[i] - WW'(1)) : rem_rel[i];
    end
    done    = found && (rem_rel[pick] == WW'(1));
    full_k  = full[pick];
    burst_k = task_cfg[pick].burst;
    tat     = rmts_pkg::sat16(full_k);
    wt      = ({{(TW-WW){1'b0}}, burst_k} > full_k) ? '0
            : rmts_pkg::sat16(full_k - {{(TW-WW){1'b0}}, burst_k});
  end

  // task registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rmts_pkg::TASK_SLOTS; i++) begin
        task_cfg[i] <= '0;
      end
    end else if (cfg_we) begin
      task_cfg[cfg_index] <= cfg_data;
    end
  end

  // scheduler state update
  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
      for (int i = 0; i < N; i++) begin
        remaining[i]    <= '0;
        next_release[i] <= '0;
        release_time[i] <= '0;
      end
    end else if (proc) begin
      now <= fin;
      for (int i = 0; i < N; i++) begin
        remaining[i]    <= remaining_next[i];
        next_release[i] <= next_release_next[i];
        release_time[i] <= rt_rel[i];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_restart_r <= restart;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      scheduled    <= found;
      task_res     <= found ? pick : '0;
      job_done     <= done;
      finish_time  <= done ? fin : '0;
      turnaround   <= done ? tat : '0;
      waiting      <= done ? wt : '0;
      overrun_mask <= ovr;
    end
  end

  // a completion always belongs to a task that ran
  `RMTS_ASSERT(a_done_needs_run, out_valid && job_done |-> scheduled)
  // an idle tick reports task zero and no completion
  `RMTS_ASSERT(a_idle_clean, out_valid && !scheduled |-> task_res == '0 && !job_done)
  // time moves by exactly one for every tick without restart
  `RMTS_ASSERT(a_now_step, proc && !in_restart_r |=> now == $past(now) + 32'd1)

endmodule
